FILE: hdl/diru_pkg.sv
`timescale 1ns / 1ps

package diru_pkg;

   localparam int MANT_WIDTH  = 96;
   localparam int LIMB_WIDTH  = 32;
   localparam int SCALE_WIDTH = 5;
   localparam int ACT_WIDTH   = 2;
   localparam int DIGIT_WIDTH = 4;

   localparam logic [SCALE_WIDTH-1:0] MAX_SCALE = 5'd28;

   localparam logic [ACT_WIDTH-1:0] ACT_TRUNCATE = 2'd0;
   localparam logic [ACT_WIDTH-1:0] ACT_FLOOR    = 2'd1;
   localparam logic [ACT_WIDTH-1:0] ACT_ROUND    = 2'd2;
   localparam logic [ACT_WIDTH-1:0] ACT_NEGATE   = 2'd3;

   // 2^32 = 10 * LIMB_QUOT + LIMB_REM
   localparam logic [LIMB_WIDTH-1:0] LIMB_QUOT = 32'd429496729;
   localparam logic [32:0]           LIMB_REM  = 33'd6;

   // ceil(2^36 / 10): exact quotient by ten for 33-bit dividends
   localparam logic [32:0] DIV_MAGIC = 33'h19999999A;
   localparam int          DIV_SHIFT = 36;

   localparam logic [1:0] LAST_LIMB = 2'd2;

   typedef struct packed {
      logic load;
      logic step;
      logic digit_end;
      logic finish;
   } cmd_type;

endpackage

FILE: hdl/diru_ctrl.sv
`timescale 1ns / 1ps

module diru_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [diru_pkg::ACT_WIDTH-1:0]     req_action,
   input  logic [diru_pkg::SCALE_WIDTH-1:0]   req_scale,
   output logic                               busy,
   output logic                               rsp_valid,
   output diru_pkg::cmd_type                  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [diru_pkg::SCALE_WIDTH-1:0]    digits_ff, digits_in;
   logic [1:0]                          limb_ff, limb_in;
   logic                                done_ff, done_in;
   logic [diru_pkg::SCALE_WIDTH-1:0]    sat_scale;
   logic                                accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign sat_scale = (req_scale > diru_pkg::MAX_SCALE) ? diru_pkg::MAX_SCALE : req_scale;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = done_ff;

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      limb_in   = limb_ff;
      done_in   = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               digits_in = sat_scale;
               limb_in   = '0;
               if ((req_action == diru_pkg::ACT_NEGATE) || (sat_scale == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (limb_ff == diru_pkg::LAST_LIMB) begin
               cmd.digit_end = 1'b1;
               limb_in       = '0;
               digits_in     = digits_ff - 5'd1;
               if (digits_ff == 5'd1) begin
                  state_in = ST_FINISH;
               end
            end else begin
               limb_in = limb_ff + 2'd1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            done_in    = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         digits_ff <= '0;
         limb_ff   <= '0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         digits_ff <= digits_in;
         limb_ff   <= limb_in;
         done_ff   <= done_in;
      end
   end

endmodule

FILE: hdl/diru_dpath.sv
`timescale 1ns / 1ps

module diru_dpath (
   input  logic                               clock,
   input  diru_pkg::cmd_type                  cmd,
   input  logic [diru_pkg::ACT_WIDTH-1:0]     req_action,
   input  logic [63:0]                        req_mantissa_low,
   input  logic [31:0]                        req_mantissa_high,
   input  logic [diru_pkg::SCALE_WIDTH-1:0]   req_scale,
   input  logic                               req_negative,
   output logic [63:0]                        rsp_result_low,
   output logic [31:0]                        rsp_result_high,
   output logic [diru_pkg::SCALE_WIDTH-1:0]   rsp_result_scale,
   output logic                               rsp_result_negative
);

   logic [diru_pkg::MANT_WIDTH-1:0]    mant_ff, mant_in;
   logic [diru_pkg::DIGIT_WIDTH-1:0]   rem_ff, rem_in;
   logic [diru_pkg::DIGIT_WIDTH-1:0]   digit_ff, digit_in;
   logic                               sticky_ff, sticky_in;
   logic [diru_pkg::ACT_WIDTH-1:0]     act_ff;
   logic [diru_pkg::SCALE_WIDTH-1:0]   scale_ff;
   logic                               neg_ff;

   logic [diru_pkg::MANT_WIDTH-1:0]    res_mant_ff;
   logic [diru_pkg::SCALE_WIDTH-1:0]   res_scale_ff;
   logic                               res_neg_ff;

   logic [diru_pkg::LIMB_WIDTH-1:0]    limb;
   logic [32:0]                        part;
   logic [65:0]                        prod;
   logic [29:0]                        part_quot;
   logic [32:0]                        part_rem;
   logic [diru_pkg::LIMB_WIDTH-1:0]    quot;
   logic                               bump;

   // one 32-bit limb of the division by ten, most significant limb first
   assign limb      = mant_ff[95:64];
   assign part      = 33'(rem_ff) * diru_pkg::LIMB_REM + 33'(limb);
   assign prod      = 66'(part) * 66'(diru_pkg::DIV_MAGIC);
   assign part_quot = prod[65:diru_pkg::DIV_SHIFT];
   assign part_rem  = part - 33'(part_quot) * 33'd10;
   assign quot      = 32'(rem_ff) * diru_pkg::LIMB_QUOT + 32'(part_quot);

   always_comb begin
      bump = 1'b0;
      case (act_ff)
         diru_pkg::ACT_FLOOR: begin
            bump = neg_ff && ((digit_ff != '0) || sticky_ff);
         end
         diru_pkg::ACT_ROUND: begin
            bump = (digit_ff > 4'd5) ||
                   ((digit_ff == 4'd5) && (sticky_ff || mant_ff[0]));
         end
         default: begin
            bump = 1'b0;
         end
      endcase
   end

   always_comb begin
      mant_in   = mant_ff;
      rem_in    = rem_ff;
      digit_in  = digit_ff;
      sticky_in = sticky_ff;
      if (cmd.load) begin
         mant_in   = {req_mantissa_high, req_mantissa_low};
         rem_in    = '0;
         digit_in  = '0;
         sticky_in = 1'b0;
      end else if (cmd.step) begin
         // rotate: after three limbs the quotient sits in its original order
         mant_in = {mant_ff[63:0], quot};
         rem_in  = part_rem[3:0];
         if (cmd.digit_end) begin
            rem_in    = '0;
            digit_in  = part_rem[3:0];
            sticky_in = sticky_ff || (digit_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      mant_ff   <= mant_in;
      rem_ff    <= rem_in;
      digit_ff  <= digit_in;
      sticky_ff <= sticky_in;
      if (cmd.load) begin
         act_ff   <= req_action;
         scale_ff <= req_scale;
         neg_ff   <= req_negative;
      end
      if (cmd.finish) begin
         if (act_ff == diru_pkg::ACT_NEGATE) begin
            res_mant_ff  <= mant_ff;
            res_scale_ff <= scale_ff;
            res_neg_ff   <= ~neg_ff;
         end else begin
            res_mant_ff  <= mant_ff + 96'(bump);
            res_scale_ff <= '0;
            res_neg_ff   <= neg_ff;
         end
      end
   end

   assign rsp_result_low      = res_mant_ff[63:0];
   assign rsp_result_high     = res_mant_ff[95:64];
   assign rsp_result_scale    = res_scale_ff;
   assign rsp_result_negative = res_neg_ff;

endmodule

FILE: hdl/decimal_integer_rounding_unit.sv
`timescale 1ns / 1ps

// Truncates, floors, rounds half to even, or negates one scaled decimal
// (96-bit mantissa, scale 0..28, sign). A request is taken when start is high
// and busy is low; its result appears on the rsp_ ports for exactly one cycle
// with rsp_valid high and must be captured then, as the receiver cannot stall.
// Truncate, floor and round divide by ten once per digit of the scale, saturated
// to 28; negate and scale zero skip the division. The divide-by-ten unit,
// shared by truncate, floor and round, handles one 32-bit limb per cycle,
// three limbs per decimal digit. busy stays high until the result is registered.

module decimal_integer_rounding_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [diru_pkg::ACT_WIDTH-1:0]     req_action,
   input  logic [63:0]                        req_mantissa_low,
   input  logic [31:0]                        req_mantissa_high,
   input  logic [diru_pkg::SCALE_WIDTH-1:0]   req_scale,
   input  logic                               req_negative,
   output logic                               rsp_valid,
   output logic [63:0]                        rsp_result_low,
   output logic [31:0]                        rsp_result_high,
   output logic [diru_pkg::SCALE_WIDTH-1:0]   rsp_result_scale,
   output logic                               rsp_result_negative
);

   diru_pkg::cmd_type cmd;

   diru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .req_scale  (req_scale),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   diru_dpath u_dpath (
      .clock               (clock),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_mantissa_low    (req_mantissa_low),
      .req_mantissa_high   (req_mantissa_high),
      .req_scale           (req_scale),
      .req_negative        (req_negative),
      .rsp_result_low      (rsp_result_low),
      .rsp_result_high     (rsp_result_high),
      .rsp_result_scale    (rsp_result_scale),
      .rsp_result_negative (rsp_result_negative)
   );

endmodule

FILE: hdl/diru_checker.sv
`timescale 1ns / 1ps

module diru_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [diru_pkg::ACT_WIDTH-1:0]     req_action,
   input logic [63:0]                        req_mantissa_low,
   input logic                               req_negative,
   input logic                               rsp_valid,
   input logic [63:0]                        rsp_result_low,
   input logic                               rsp_result_negative
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_negate: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == diru_pkg::ACT_NEGATE)) |-> ##2
      (rsp_valid && (rsp_result_negative == !$past(req_negative, 2)) &&
       (rsp_result_low == $past(req_mantissa_low, 2))))
      else $error("negate result wrong");

endmodule

bind decimal_integer_rounding_unit diru_checker u_diru_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_action          (req_action),
   .req_mantissa_low    (req_mantissa_low),
   .req_negative        (req_negative),
   .rsp_valid           (rsp_valid),
   .rsp_result_low      (rsp_result_low),
   .rsp_result_negative (rsp_result_negative)
);
